// File: design/bed_pkg.sv
// shared types, codes and window kernel for the 3x3 binary morphology block
`timescale 1ns / 1ps
package bed_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CONNECTIVITY = 2'd2;
    localparam logic [1:0] CFG_OPERATION    = 2'd3;

    // item opcodes
    localparam logic OPC_PIXEL = 1'b0;
    localparam logic OPC_FLUSH = 1'b1;

    // operation codes
    localparam logic [2:0] OP_ERODE     = 3'd0;
    localparam logic [2:0] OP_DILATE    = 3'd1;
    localparam logic [2:0] OP_GRADIENT  = 3'd2;
    localparam logic [2:0] OP_GRAD_INT  = 3'd3;
    localparam logic [2:0] OP_GRAD_EXT  = 3'd4;

    // neighborhood masks, bit index = row*3 + column
    localparam logic [8:0] NBR_CROSS  = 9'h0AA;
    localparam logic [8:0] NBR_SQUARE = 9'h1EF;

    // window positions that fall outside the frame at each border
    localparam logic [8:0] MASK_TOP    = 9'h007;
    localparam logic [8:0] MASK_BOTTOM = 9'h1C0;
    localparam logic [8:0] MASK_LEFT   = 9'h049;
    localparam logic [8:0] MASK_RIGHT  = 9'h124;

    localparam logic [7:0] PIXEL_ON  = 8'd255;
    localparam logic [7:0] PIXEL_OFF = 8'd0;

    // border position of the output pixel
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic frame_end;
    } border_t;

    function automatic logic morph_pixel(
        input logic [8:0] win,
        input border_t    border,
        input logic       conn,
        input logic [2:0] op
    );
        logic [8:0] valid;
        logic [8:0] nbr;
        logic [8:0] seen;
        logic       centre;
        logic       ero;
        logic       dil;
        logic       res;
        valid = 9'h1FF;
        if (border.top)    valid = valid & ~MASK_TOP;
        if (border.bottom) valid = valid & ~MASK_BOTTOM;
        if (border.left)   valid = valid & ~MASK_LEFT;
        if (border.right)  valid = valid & ~MASK_RIGHT;
        nbr    = conn ? NBR_SQUARE : NBR_CROSS;
        centre = win[4];
        seen   = win & valid & nbr;
        ero    = centre && (seen == nbr);
        dil    = centre || (seen != 9'd0);
        case (op)
            OP_ERODE:    res = ero;
            OP_DILATE:   res = dil;
            OP_GRADIENT: res = dil & ~ero;
            OP_GRAD_INT: res = centre & ~ero;
            OP_GRAD_EXT: res = dil & ~centre;
            default:     res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// File: design/binary_erode_dilate_3x3.sv
// top level of the streaming 3x3 binary erosion / dilation block
// a result passes stage b and then the output register after its item is accepted
// (the output pixel trails the input stream by one image row plus one pixel of items)
// throughput: one item per cycle unless stalled, each buffer one read and write a cycle
// reset: counters, window and output valid clear, configuration returns to its defaults;
// line buffers are not cleared, border masking hides entries not yet written
`timescale 1ns / 1ps
module binary_erode_dilate_3x3
    import bed_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_wdata,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [7:0]  s_pixel_in,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pixel_out,
    output logic        m_frame_end
);

    // column index, dimension and row counter widths
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 2);
    localparam int WIDTH_RST  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int HEIGHT_RST = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    // ------------------------------------------------------------------
    // configuration, dimensions stored already clamped to 1..max
    // ------------------------------------------------------------------
    logic [DW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic          conn_reg;
    logic [2:0]    op_reg;
    int            cfg_val;

    assign cfg_val = int'(cfg_wdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DW'(WIDTH_RST);
            height_reg <= HW'(HEIGHT_RST);
            conn_reg   <= 1'b1;
            op_reg     <= OP_ERODE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_WIDTH: begin
                    if (cfg_val == 0) begin
                        width_reg <= DW'(1);
                    end else if (cfg_val > MAX_WIDTH) begin
                        width_reg <= DW'(MAX_WIDTH);
                    end else begin
                        width_reg <= DW'(cfg_val);
                    end
                end
                CFG_FRAME_HEIGHT: begin
                    if (cfg_val == 0) begin
                        height_reg <= HW'(1);
                    end else if (cfg_val > MAX_HEIGHT) begin
                        height_reg <= HW'(MAX_HEIGHT);
                    end else begin
                        height_reg <= HW'(cfg_val);
                    end
                end
                CFG_CONNECTIVITY: conn_reg <= cfg_wdata[0];
                CFG_OPERATION:    op_reg   <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: stage b holds the item whose buffer reads are in flight
    // ------------------------------------------------------------------
    logic    b_valid_reg;
    logic    b_emit_reg;
    logic    b_bit_reg;
    logic [CW-1:0] b_col_reg;
    border_t b_border_reg;
    logic    m_valid_reg;
    logic    out_free;
    logic    b_go;
    logic    accept;

    assign out_free = !m_valid_reg || m_ready;
    // an item that makes no result passes without an output slot
    assign b_go     = b_valid_reg && (out_free || !b_emit_reg);
    assign s_ready  = !b_valid_reg || b_go;
    assign accept   = s_valid && s_ready;

    // ------------------------------------------------------------------
    // raster position of the accepted item and of the pixel it completes
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic          col_wrap;
    logic [CW-1:0] a_col;
    logic [RW-1:0] a_row;
    logic          a_emit;
    logic [CW-1:0] ox;
    logic [RW-1:0] oy;
    border_t       a_border;
    logic          row_done;
    logic          a_bit;

    always_comb begin
        // width shrunk between frames: wrap to the next row
        col_wrap = 32'(col_reg) >= 32'(width_reg);
        a_col    = col_wrap ? '0 : col_reg;
        a_row    = col_wrap ? RW'(row_reg + RW'(1)) : row_reg;
        a_emit   = (32'(a_row) >= 32'd2) || ((32'(a_row) == 32'd1) && (a_col != '0));

        if (a_col != '0) begin
            ox = CW'(a_col - CW'(1));
            oy = RW'(a_row - RW'(1));
        end else begin
            ox = CW'(width_reg - DW'(1));
            oy = RW'(a_row - RW'(2));
        end

        a_border.top       = (oy == '0);
        a_border.bottom    = (32'(oy) + 32'd1) >= 32'(height_reg);
        a_border.left      = (ox == '0);
        a_border.right     = (32'(ox) + 32'd1) >= 32'(width_reg);
        a_border.frame_end = a_emit && a_border.right && a_border.bottom;

        row_done = (32'(a_col) + 32'd1) >= 32'(width_reg);
        if (a_border.frame_end) begin
            col_next = '0;
            row_next = '0;
        end else if (row_done) begin
            col_next = '0;
            row_next = RW'(a_row + RW'(1));
        end else begin
            col_next = CW'(a_col + CW'(1));
            row_next = a_row;
        end

        a_bit = (s_opcode == OPC_PIXEL) && (s_pixel_in != 8'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // line buffers: middle written on accept, upper written as the item
    // leaves stage b with the middle bit it read
    // ------------------------------------------------------------------
    logic up_rd;
    logic mid_rd;
    logic byp_hit;
    logic byp_reg;
    logic byp_val_reg;
    logic up_bit;

    bed_line_buffer #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_lb_middle (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (a_col),
        .wr_data (a_bit),
        .rd_en   (accept),
        .rd_addr (a_col),
        .rd_data (mid_rd)
    );

    bed_line_buffer #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_lb_upper (
        .aclk    (aclk),
        .wr_en   (b_go),
        .wr_addr (b_col_reg),
        .wr_data (mid_rd),
        .rd_en   (accept),
        .rd_addr (a_col),
        .rd_data (up_rd)
    );

    // one-pixel rows: the upper write of the item ahead lands on the same edge
    assign byp_hit = b_valid_reg && (b_col_reg == a_col);

    always_ff @(posedge aclk) begin
        if (accept) begin
            byp_reg      <= byp_hit;
            byp_val_reg  <= mid_rd;
            b_col_reg    <= a_col;
            b_bit_reg    <= a_bit;
            b_emit_reg   <= a_emit;
            b_border_reg <= a_border;
        end
    end

    assign up_bit = byp_reg ? byp_val_reg : up_rd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (accept) begin
            b_valid_reg <= 1'b1;
        end else if (b_go) begin
            b_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // window: two column cells hold the left and middle columns, the new
    // column enters on the right and the leftmost one drops out
    // ------------------------------------------------------------------
    logic [2:0] cell_in [3];
    logic [2:0] cell_q  [1:2];
    logic [8:0] win_next;

    assign cell_in[2] = {b_bit_reg, mid_rd, up_bit};

    for (genvar c = 0; c < 3; c++) begin : g_cell
        if (c < 2) begin : g_link
            assign cell_in[c] = cell_q[c + 1];
        end
        if (c > 0) begin : g_hold
            bed_window_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (b_go),
                .col_in   (cell_in[c]),
                .col_out  (cell_q[c])
            );
        end
        for (genvar r = 0; r < 3; r++) begin : g_row
            assign win_next[r * 3 + c] = cell_in[c][r];
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [7:0] m_pixel_out_reg;
    logic       m_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_go && b_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_go && b_emit_reg) begin
            m_pixel_out_reg <= morph_pixel(win_next, b_border_reg, conn_reg, op_reg)
                               ? PIXEL_ON : PIXEL_OFF;
            m_frame_end_reg <= b_border_reg.frame_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pixel_out = m_pixel_out_reg;
    assign m_frame_end = m_frame_end_reg;

endmodule

// File: design/bed_line_buffer.sv
// one-bit line buffer memory with one write port and a registered read port
`timescale 1ns / 1ps
module bed_line_buffer #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);

    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-before-write on a shared address
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/bed_window_cell.sv
// one column of the 3x3 window, handed to its left neighbor on every shift
`timescale 1ns / 1ps
module bed_window_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       shift_en,
    input  logic [2:0] col_in,
    output logic [2:0] col_out
);

    logic [2:0] col_reg;
    logic [2:0] col_next;

    assign col_next = shift_en ? col_in : col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= 3'd0;
        end else begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

endmodule
